@@ rtl/fenw2d_pkg.sv @@
`default_nettype none

package fenw2d_pkg;

    localparam int COORD_W = 10;
    localparam int DELTA_W = 16;
    localparam int SUM_W   = 64;
    localparam int SIDE_W  = 11;

    localparam logic [SIDE_W-1:0] GRID_SIDE_RESET = 11'd1024;

    localparam logic MODE_ADD   = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    localparam logic [1:0] TERM_FULL   = 2'd0;
    localparam logic [1:0] TERM_LEFT   = 2'd1;
    localparam logic [1:0] TERM_TOP    = 2'd2;
    localparam logic [1:0] TERM_CORNER = 2'd3;

    typedef struct packed {
        logic load;
        logic next_term;
        logic rd;
        logic consume;
        logic clr_wr;
        logic publish;
    } t_cmd;

    typedef struct packed {
        logic walk_ok;
        logic is_query;
        logic term_last;
        logic clr_last;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

@@ rtl/fenwick_2d_rectangle_sum.sv @@
// Two-dimensional binary indexed tree over a SIDE by SIDE grid of 64-bit counters.
// Input beats (valid/ready) carry a mode, four coordinates and a delta. An add beat
// updates one cell and produces no output beat; a query beat produces one output
// beat with the inclusive rectangle sum, wrapping at 64 bits.
// The config channel is always ready and writes grid_side at every edge where its
// valid is high, so it should only be written while no input beat is in flight.
// Every tree node visit goes through the node memory in S_WALK, which issues the
// registered read, and then S_READ, which uses the data or writes it back.
// An add visits the nodes on its update path, roughly log2(side) squared of them.
// A query makes four prefix walks, one for each term of the rectangle sum.
// After reset the node memory is cleared one entry a cycle, all SIDE * SIDE entries,
// and no input beat is accepted until that pass ends.
// The result sits in an output register, so the next input beat is accepted while
// the receiver stalls; a query that finishes while that register is still full
// waits for it to drain.
`default_nettype none

module fenwick_2d_rectangle_sum #(
    parameter int SIDE = 1024
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [fenw2d_pkg::SIDE_W-1:0]         i_cfg_grid_side,
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_ready,
    input  wire logic                                  i_mode,
    input  wire logic [fenw2d_pkg::COORD_W-1:0]        i_row_low,
    input  wire logic [fenw2d_pkg::COORD_W-1:0]        i_col_low,
    input  wire logic [fenw2d_pkg::COORD_W-1:0]        i_row_high,
    input  wire logic [fenw2d_pkg::COORD_W-1:0]        i_col_high,
    input  wire logic signed [fenw2d_pkg::DELTA_W-1:0] i_delta,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_ready,
    output logic signed [fenw2d_pkg::SUM_W-1:0]        o_rectangle_sum
);

    fenw2d_pkg::t_cmd cmd;
    fenw2d_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    fenw2d_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    fenw2d_dp #(
        .SIDE(SIDE)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_grid_side(i_cfg_grid_side),
        .i_mode         (i_mode),
        .i_row_low      (i_row_low),
        .i_col_low      (i_col_low),
        .i_row_high     (i_row_high),
        .i_col_high     (i_col_high),
        .i_delta        (i_delta),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_rectangle_sum(o_rectangle_sum),
        .i_cmd          (cmd),
        .o_sts          (sts)
    );

endmodule

`default_nettype wire

@@ rtl/fenw2d_ram.sv @@
`default_nettype none

module fenw2d_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/fenw2d_ctrl.sv @@
`default_nettype none

module fenw2d_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire fenw2d_pkg::t_sts  i_sts,
    output fenw2d_pkg::t_cmd       o_cmd
);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_WALK  = 5'b00100,
        S_READ  = 5'b01000,
        S_FIN   = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_WALK;
                end
            end
            S_WALK: begin
                if (i_sts.walk_ok) begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_READ;
                end else if (!i_sts.is_query) begin
                    n_state = S_IDLE;
                end else if (i_sts.term_last) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.next_term = 1'b1;
                end
            end
            S_READ: begin
                o_cmd.consume = 1'b1;
                n_state       = S_WALK;
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.publish = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/fenw2d_dp.sv @@
`default_nettype none

module fenw2d_dp #(
    parameter int SIDE = 1024
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_valid,
    input  wire logic [fenw2d_pkg::SIDE_W-1:0]         i_cfg_grid_side,
    input  wire logic                                  i_mode,
    input  wire logic [fenw2d_pkg::COORD_W-1:0]        i_row_low,
    input  wire logic [fenw2d_pkg::COORD_W-1:0]        i_col_low,
    input  wire logic [fenw2d_pkg::COORD_W-1:0]        i_row_high,
    input  wire logic [fenw2d_pkg::COORD_W-1:0]        i_col_high,
    input  wire logic signed [fenw2d_pkg::DELTA_W-1:0] i_delta,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_ready,
    output logic signed [fenw2d_pkg::SUM_W-1:0]        o_rectangle_sum,
    input  wire fenw2d_pkg::t_cmd                      i_cmd,
    output fenw2d_pkg::t_sts                           o_sts
);

    localparam int IW    = $clog2(SIDE + 1);
    localparam int WW    = IW + 1;
    localparam int RW    = $clog2(SIDE);
    localparam int DEPTH = SIDE * SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = fenw2d_pkg::SUM_W;

    function automatic logic [WW-1:0] f_clamp1(logic [fenw2d_pkg::COORD_W-1:0] c,
                                               logic [IW-1:0] n);
        logic [IW-1:0] v;
        if (32'(c) >= 32'(n)) begin
            v = n - 1'b1;
        end else begin
            v = IW'(c);
        end
        return WW'(v) + 1'b1;
    endfunction

    function automatic logic [WW-1:0] f_lb(logic [WW-1:0] x);
        return x & (~x + 1'b1);
    endfunction

    logic [fenw2d_pkg::SIDE_W-1:0]  r_side;
    logic [AW-1:0]                  r_clr;
    logic                           r_out_valid;
    logic [SW-1:0]                  r_sum;
    logic                           r_mode;
    logic [WW-1:0]                  r_r0;
    logic [WW-1:0]                  r_c0;
    logic [WW-1:0]                  r_r1;
    logic [WW-1:0]                  r_c1;
    logic [fenw2d_pkg::DELTA_W-1:0] r_delta;
    logic [1:0]                     r_term;
    logic [WW-1:0]                  r_i;
    logic [WW-1:0]                  r_j;
    logic [WW-1:0]                  r_cs;
    logic [SW-1:0]                  r_acc;

    logic [IW-1:0] n_use;
    logic [WW-1:0] n_wide;
    logic [WW-1:0] c_r0;
    logic [WW-1:0] c_c0;
    logic [WW-1:0] c_r1;
    logic [WW-1:0] c_c1;
    logic          is_add;
    logic          i_ok;
    logic          j_ok;
    logic [WW-1:0] i_next;
    logic [WW-1:0] j_next;
    logic          j_next_ok;
    logic [AW-1:0] node_addr;
    logic [SW-1:0] delta_ext;
    logic [SW-1:0] rdata;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [SW-1:0] ram_wdata;
    logic [1:0]    term_nxt;

    always_comb begin
        if (r_side == '0) begin
            n_use = IW'(1);
        end else if (32'(r_side) > 32'(SIDE)) begin
            n_use = IW'(SIDE);
        end else begin
            n_use = IW'(r_side);
        end
    end

    assign n_wide = WW'(n_use);
    assign c_r0   = f_clamp1(i_row_low, n_use);
    assign c_c0   = f_clamp1(i_col_low, n_use);
    assign c_r1   = f_clamp1(i_row_high, n_use);
    assign c_c1   = f_clamp1(i_col_high, n_use);

    assign is_add = (r_mode == fenw2d_pkg::MODE_ADD);
    assign i_ok   = (r_i != '0) && (!is_add || (r_i <= n_wide));
    assign j_ok   = (r_j != '0) && (!is_add || (r_j <= n_wide));
    assign i_next = is_add ? (r_i + f_lb(r_i)) : (r_i - f_lb(r_i));
    assign j_next = is_add ? (r_j + f_lb(r_j)) : (r_j - f_lb(r_j));
    assign j_next_ok = is_add ? (j_next <= n_wide) : (j_next != '0);

    assign node_addr = AW'(RW'(r_i - 1'b1)) * AW'(SIDE) + AW'(RW'(r_j - 1'b1));
    assign delta_ext = {{(SW - fenw2d_pkg::DELTA_W){r_delta[fenw2d_pkg::DELTA_W-1]}},
                        r_delta};
    assign term_nxt  = r_term + 1'b1;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = node_addr;
        ram_wdata = rdata + delta_ext;
        if (i_cmd.clr_wr) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr;
            ram_wdata = '0;
        end else if (i_cmd.consume && is_add) begin
            ram_we = 1'b1;
        end
    end

    fenw2d_ram #(
        .WIDTH(SW),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (i_cmd.rd),
        .i_raddr(node_addr),
        .o_rdata(rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side      <= fenw2d_pkg::GRID_SIDE_RESET;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_side <= i_cfg_grid_side;
            end
            if (i_cmd.clr_wr) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.publish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            r_sum <= r_acc;
        end
        if (i_cmd.load) begin
            r_mode  <= i_mode;
            r_r0    <= c_r0;
            r_c0    <= c_c0;
            r_r1    <= c_r1;
            r_c1    <= c_c1;
            r_delta <= i_delta;
            r_term  <= fenw2d_pkg::TERM_FULL;
            r_acc   <= '0;
            if (i_mode == fenw2d_pkg::MODE_ADD) begin
                r_i  <= c_r0;
                r_j  <= c_c0;
                r_cs <= c_c0;
            end else begin
                r_i  <= c_r1;
                r_j  <= c_c1;
                r_cs <= c_c1;
            end
        end else if (i_cmd.next_term) begin
            r_term <= term_nxt;
            case (term_nxt)
                fenw2d_pkg::TERM_LEFT: begin
                    r_i  <= r_r1;
                    r_j  <= r_c0 - 1'b1;
                    r_cs <= r_c0 - 1'b1;
                end
                fenw2d_pkg::TERM_TOP: begin
                    r_i  <= r_r0 - 1'b1;
                    r_j  <= r_c1;
                    r_cs <= r_c1;
                end
                fenw2d_pkg::TERM_CORNER: begin
                    r_i  <= r_r0 - 1'b1;
                    r_j  <= r_c0 - 1'b1;
                    r_cs <= r_c0 - 1'b1;
                end
                default: begin
                    r_i <= '0;
                end
            endcase
        end else if (i_cmd.consume) begin
            if (!is_add) begin
                if ((r_term == fenw2d_pkg::TERM_LEFT) || (r_term == fenw2d_pkg::TERM_TOP)) begin
                    r_acc <= r_acc - rdata;
                end else begin
                    r_acc <= r_acc + rdata;
                end
            end
            if (j_next_ok) begin
                r_j <= j_next;
            end else begin
                r_i <= i_next;
                r_j <= r_cs;
            end
        end
    end

    assign o_sts.walk_ok   = i_ok && j_ok;
    assign o_sts.is_query  = (r_mode == fenw2d_pkg::MODE_QUERY);
    assign o_sts.term_last = (r_term == fenw2d_pkg::TERM_CORNER);
    assign o_sts.clr_last  = (r_clr == AW'(DEPTH - 1));
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid     = r_out_valid;
    assign o_rectangle_sum = r_sum;

endmodule

`default_nettype wire
